// ===== rtl/gcv_pkg.sv =====
// Shared types, constants and codes for the 3x3 grayscale convolution block.
`default_nettype none

package gcv_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KERNEL_TAPS   = 9;
    localparam int MIN_DIM       = 3;
    localparam int MAX_HEIGHT    = 4095;

    // Position compares run at this width; covers the largest MAX_WIDTH.
    localparam int POS_W     = 13;
    localparam int ROW_W     = 12;
    localparam int OUT_COL_W = 10;
    localparam int PIX_W     = 8;
    localparam int TAP_W     = 8;
    localparam int SCALE_W   = 16;
    localparam int ACC_W     = 20;
    localparam int PROD_W    = 37;
    localparam int FRAC_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam logic [63:0] TAPS_RST     = 64'h0000_0001_0000_0000;
    localparam logic [7:0]  TAP_LAST_RST = 8'd0;
    localparam logic [15:0] SCALE_RST    = 16'd4096;
    localparam logic [1:0]  CENTER_RST   = 2'd1;
    localparam logic [10:0] WIDTH_RST    = 11'd640;
    localparam logic [11:0] HEIGHT_RST   = 12'd480;
    localparam logic [7:0]  PIX_MAX      = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPS       = 3'd0,
        CFG_TAP_LAST   = 3'd1,
        CFG_SCALE      = 3'd2,
        CFG_CENTER_ROW = 3'd3,
        CFG_CENTER_COL = 3'd4,
        CFG_WIDTH      = 3'd5,
        CFG_HEIGHT     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0] taps;
        logic [7:0]  tap_last;
        logic [15:0] scale;
        logic [1:0]  center_row;
        logic [1:0]  center_col;
        logic [10:0] image_width;
        logic [11:0] image_height;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_MAC,
        S_SCALE,
        S_ROUND
    } state_t;

    typedef struct packed {
        logic accept;
        logic shift;
        logic mac_clear;
        logic mac_step;
        logic scale;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic mac_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/grayscale_convolution_3x3_top.sv =====
// Top level of the 3x3 grayscale convolution block.
//
// Usage:
//   Input channel (in_valid / in_stall, gray, frame_start) takes one pixel
//   beat in raster order; frame_start forces that pixel to column 0, row 0.
//   Output channel (out_valid / out_stall) delivers one beat per pixel whose
//   3x3 window lies inside the image, carrying the rounded, saturated
//   magnitude of the scaled weighted sum and the anchor coordinates.
//   Border pixels give no beat. Configuration (cfg_valid / cfg_ready,
//   cfg_index, cfg_data) is always ready; write it only while idle.
// Timing:
//   A border pixel takes accept and window shift only. An interior pixel takes
//   accept, window shift, 9 steps through the single shared tap multiplier,
//   one scale multiply and one round/saturate step; out_valid rises on the
//   cycle after that last step. The shared multiplier sets the rate.
// Reset (rst_n low, asynchronous): registers return to defaults, position
//   goes to (0,0), window clears, output goes empty. Line memories are not
//   cleared; their entries are written before any emitted window reads them.
// Stall: in_stall is high in every cycle but idle. A result waits in the
//   output register while the next pixel is taken; a receiver stall only
//   lengthens an item when its result reaches the round step before the
//   previous beat has left, and then holds there until it does.
`default_nettype none

module grayscale_convolution_3x3_top #(
    parameter int MAX_WIDTH = gcv_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [gcv_pkg::PIX_W-1:0]     gray,
    input  wire logic                          frame_start,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [gcv_pkg::PIX_W-1:0]          result_gray,
    output logic [gcv_pkg::OUT_COL_W-1:0]      out_col,
    output logic [gcv_pkg::ROW_W-1:0]          out_row,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gcv_pkg::CFG_DAT_W-1:0] cfg_data
);

    gcv_pkg::cfg_t    cfg;
    gcv_pkg::cmd_t    cmd;
    gcv_pkg::status_t status;

    // register file: always ready, applies each write beat at once
    gcv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: accept, shift, accumulate, scale, deliver
    gcv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // line buffers, window, arithmetic and output register
    gcv_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .gray        (gray),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_gray (result_gray),
        .out_col     (out_col),
        .out_row     (out_row)
    );

endmodule

`default_nettype wire

// ===== rtl/gcv_cfg.sv =====
// Configuration register file for the convolution block.
`default_nettype none

module gcv_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gcv_pkg::CFG_DAT_W-1:0] cfg_data,
    output gcv_pkg::cfg_t                      cfg
);

    gcv_pkg::cfg_t cfg_reg;
    gcv_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (gcv_pkg::cfg_idx_t'(cfg_index))
                gcv_pkg::CFG_TAPS:       cfg_next.taps         = cfg_data;
                gcv_pkg::CFG_TAP_LAST:   cfg_next.tap_last     = cfg_data[7:0];
                gcv_pkg::CFG_SCALE:      cfg_next.scale        = cfg_data[15:0];
                gcv_pkg::CFG_CENTER_ROW: cfg_next.center_row   = cfg_data[1:0];
                gcv_pkg::CFG_CENTER_COL: cfg_next.center_col   = cfg_data[1:0];
                gcv_pkg::CFG_WIDTH:      cfg_next.image_width  = cfg_data[10:0];
                gcv_pkg::CFG_HEIGHT:     cfg_next.image_height = cfg_data[11:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.taps         <= gcv_pkg::TAPS_RST;
            cfg_reg.tap_last     <= gcv_pkg::TAP_LAST_RST;
            cfg_reg.scale        <= gcv_pkg::SCALE_RST;
            cfg_reg.center_row   <= gcv_pkg::CENTER_RST;
            cfg_reg.center_col   <= gcv_pkg::CENTER_RST;
            cfg_reg.image_width  <= gcv_pkg::WIDTH_RST;
            cfg_reg.image_height <= gcv_pkg::HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gcv_ctrl.sv =====
// Sequencing state machine for the convolution block.
`default_nettype none

module gcv_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  gcv_pkg::status_t      status,
    output gcv_pkg::cmd_t         cmd
);

    gcv_pkg::state_t state_reg;
    gcv_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcv_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            gcv_pkg::S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = gcv_pkg::S_SHIFT;
                end
            end
            gcv_pkg::S_SHIFT:
            begin
                cmd.shift     = 1'b1;
                cmd.mac_clear = 1'b1;
                state_next    = status.emit ? gcv_pkg::S_MAC : gcv_pkg::S_IDLE;
            end
            gcv_pkg::S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.mac_last)
                begin
                    state_next = gcv_pkg::S_SCALE;
                end
            end
            gcv_pkg::S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = gcv_pkg::S_ROUND;
            end
            gcv_pkg::S_ROUND:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = gcv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gcv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gcv_datapath.sv =====
// Line buffers, window, position counters, MAC, scaling and output register.
`default_nettype none

module gcv_datapath #(
    parameter int MAX_WIDTH = gcv_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  gcv_pkg::cfg_t                      cfg,
    input  gcv_pkg::cmd_t                      cmd,
    output gcv_pkg::status_t                   status,
    input  wire logic [gcv_pkg::PIX_W-1:0]     gray,
    input  wire logic                          frame_start,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [gcv_pkg::PIX_W-1:0]          result_gray,
    output logic [gcv_pkg::OUT_COL_W-1:0]      out_col,
    output logic [gcv_pkg::ROW_W-1:0]          out_row
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int POS_W  = gcv_pkg::POS_W;
    localparam int ROW_W  = gcv_pkg::ROW_W;
    localparam int PIX_W  = gcv_pkg::PIX_W;
    localparam int ACC_W  = gcv_pkg::ACC_W;
    localparam int PROD_W = gcv_pkg::PROD_W;
    localparam int NTAP   = gcv_pkg::KERNEL_TAPS;
    localparam int K_W    = $clog2(NTAP);

    // line memories: lo holds row r-2, hi holds row r-1
    logic [PIX_W-1:0] mem_lo [MAX_WIDTH];
    logic [PIX_W-1:0] mem_hi [MAX_WIDTH];
    logic [PIX_W-1:0] rd_lo_reg;
    logic [PIX_W-1:0] rd_hi_reg;

    logic [PIX_W-1:0] window_reg [NTAP];
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [COL_W-1:0] c_reg;
    logic [ROW_W-1:0] r_reg;
    logic [PIX_W-1:0] px_reg;

    logic [K_W-1:0]          k_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                             out_valid_reg;
    logic [PIX_W-1:0]                 result_reg;
    logic [gcv_pkg::OUT_COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]                 out_row_reg;

    // effective dimensions and anchor
    logic [POS_W-1:0] width_ext;
    logic [POS_W-1:0] height_ext;
    logic [POS_W-1:0] w_eff;
    logic [POS_W-1:0] h_eff;
    logic [1:0]       cr_eff;
    logic [1:0]       cc_eff;

    always_comb
    begin
        width_ext  = POS_W'(cfg.image_width);
        height_ext = POS_W'(cfg.image_height);
        priority if (width_ext < POS_W'(gcv_pkg::MIN_DIM))
            w_eff = POS_W'(gcv_pkg::MIN_DIM);
        else if (width_ext > POS_W'(MAX_WIDTH))
            w_eff = POS_W'(MAX_WIDTH);
        else
            w_eff = width_ext;
        priority if (height_ext < POS_W'(gcv_pkg::MIN_DIM))
            h_eff = POS_W'(gcv_pkg::MIN_DIM);
        else if (height_ext > POS_W'(gcv_pkg::MAX_HEIGHT))
            h_eff = POS_W'(gcv_pkg::MAX_HEIGHT);
        else
            h_eff = height_ext;
        cr_eff = (cfg.center_row > 2'd2) ? 2'd2 : cfg.center_row;
        cc_eff = (cfg.center_col > 2'd2) ? 2'd2 : cfg.center_col;
    end

    // position of the pixel being accepted
    logic [COL_W-1:0] col_start;
    logic [ROW_W-1:0] row_start;
    logic [COL_W-1:0] col_cur;
    logic [POS_W-1:0] row_step;
    logic [ROW_W-1:0] row_cur;

    always_comb
    begin
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;
        if (POS_W'(col_start) >= w_eff)
        begin
            col_cur  = '0;
            row_step = POS_W'(row_start) + POS_W'(1);
        end
        else
        begin
            col_cur  = col_start;
            row_step = POS_W'(row_start);
        end
        row_cur = (row_step >= h_eff) ? '0 : row_step[ROW_W-1:0];
    end

    // position after the current pixel
    logic [POS_W-1:0] col_inc;
    logic [POS_W-1:0] row_inc;

    always_comb
    begin
        col_inc = POS_W'(c_reg) + POS_W'(1);
        row_inc = POS_W'(r_reg) + POS_W'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_lo_reg <= mem_lo[col_cur];
            rd_hi_reg <= mem_hi[col_cur];
            c_reg     <= col_cur;
            r_reg     <= row_cur;
            px_reg    <= gray;
        end
        if (cmd.shift)
        begin
            mem_lo[c_reg] <= rd_hi_reg;
            mem_hi[c_reg] <= px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < NTAP; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (cmd.shift)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            for (int k = 0; k < 3; k++)
            begin
                window_reg[3*k]     <= window_reg[3*k + 1];
                window_reg[3*k + 1] <= window_reg[3*k + 2];
            end
            window_reg[2] <= rd_lo_reg;
            window_reg[5] <= rd_hi_reg;
            window_reg[8] <= px_reg;
        end
    end

    // shared multiply-accumulate, one tap per cycle
    logic signed [gcv_pkg::TAP_W-1:0] tap_sel;
    logic signed [16:0]               mac_prod;

    always_comb
    begin
        if (k_reg == K_W'(NTAP - 1))
            tap_sel = $signed(cfg.tap_last);
        else
            tap_sel = $signed(cfg.taps[8*k_reg[2:0] +: 8]);
        mac_prod = $signed({1'b0, window_reg[k_reg]}) * tap_sel;
    end

    // hold the tap counter on the last tap once the final step is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cmd.mac_clear)
        begin
            k_reg <= '0;
        end
        else if (cmd.mac_step && (k_reg != K_W'(NTAP - 1)))
        begin
            k_reg <= k_reg + K_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_clear)
            acc_reg <= '0;
        else if (cmd.mac_step)
            acc_reg <= acc_reg + ACC_W'(mac_prod);
        if (cmd.scale)
            prod_reg <= PROD_W'(acc_reg) * PROD_W'($signed({1'b0, cfg.scale}));
    end

    // magnitude, round half up, saturate
    logic [PROD_W-1:0]               mag;
    logic [PROD_W-1:0]               rounded;
    logic [PROD_W-gcv_pkg::FRAC_W-1:0] val_wide;
    logic [PIX_W-1:0]                val_sat;
    logic [POS_W-1:0]                col_sum;

    always_comb
    begin
        mag      = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        rounded  = mag + PROD_W'(1 << (gcv_pkg::FRAC_W - 1));
        val_wide = rounded[PROD_W-1:gcv_pkg::FRAC_W];
        val_sat  = (val_wide > (PROD_W-gcv_pkg::FRAC_W)'(gcv_pkg::PIX_MAX))
                   ? gcv_pkg::PIX_MAX : val_wide[PIX_W-1:0];
        col_sum  = POS_W'(c_reg) - POS_W'(2) + POS_W'(cc_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg  <= val_sat;
            out_col_reg <= col_sum[gcv_pkg::OUT_COL_W-1:0];
            out_row_reg <= r_reg - ROW_W'(2) + ROW_W'(cr_eff);
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_gray = result_reg;
    assign out_col     = out_col_reg;
    assign out_row     = out_row_reg;

    assign status.emit     = (c_reg >= COL_W'(2)) && (r_reg >= ROW_W'(2));
    assign status.mac_last = (k_reg == K_W'(NTAP - 1));
    assign status.out_free = !out_valid_reg || !out_stall;

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= K_W'(NTAP - 1))
        else $error("tap counter past last tap");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(gcv_pkg::MAX_HEIGHT - 1))
        else $error("row position beyond largest image");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        POS_W'(col_reg) < POS_W'(MAX_WIDTH))
        else $error("column position beyond line buffer");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending beat");

endmodule

`default_nettype wire
